// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the morse flash encoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// condition never holds
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/core/mcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfe_pkg
// Types, constants and the Morse code table of the flash encoder core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfe_pkg;

   localparam int CharWidth       = 8;
   localparam int DurWidth        = 16;
   localparam int CsrIndexWidth   = 4;
   localparam int CountWidth      = 3;
   localparam int DashWidth       = 5;
   localparam int QueueDepth      = 2;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [CsrIndexWidth-1:0] CsrDotDuration  = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CsrDashDuration = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSymbolGap    = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CsrCharacterGap = 4'd3;

   localparam logic [DurWidth-1:0] DotDurationReset  = 16'd250;
   localparam logic [DurWidth-1:0] DashDurationReset = 16'd500;
   localparam logic [DurWidth-1:0] SymbolGapReset    = 16'd500;
   localparam logic [DurWidth-1:0] CharacterGapReset = 16'd500;

   localparam logic [CharWidth-1:0] CharZero = 8'h30;
   localparam logic [CharWidth-1:0] CharNine = 8'h39;
   localparam logic [CharWidth-1:0] CharA    = 8'h41;
   localparam logic [CharWidth-1:0] CharZ    = 8'h5A;

   localparam logic [CountWidth-1:0] MaxSymbols = 3'd5;

   // bits 7..5 symbol count, bit i set when symbol i is a dash
   localparam logic [7:0] DigitCodes [0:9] = '{
      8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF
   };

   localparam logic [7:0] LetterCodes [0:25] = '{
      8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
      8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
      8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
   };

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [DashWidth-1:0]  dashes;
   } code_type;

   typedef struct packed {
      logic     valid;
      code_type code;
   } code_msg_type;

   typedef struct packed {
      logic [DurWidth-1:0] dot_duration;
      logic [DurWidth-1:0] dash_duration;
      logic [DurWidth-1:0] symbol_gap;
      logic [DurWidth-1:0] character_gap;
   } timing_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LIT,
      BK_GAP,
      BK_END
   } back_state_type;

   function automatic code_type lookup_code(input logic [CharWidth-1:0] ch);
      logic [CharWidth-1:0] digit_off;
      logic [CharWidth-1:0] letter_off;
      code_type             code;
      digit_off  = ch - CharZero;
      letter_off = ch - CharA;
      code       = '0;
      if (ch >= CharZero && ch <= CharNine) begin
         code = code_type'(DigitCodes[digit_off[3:0]]);
      end else if (ch >= CharA && ch <= CharZ) begin
         code = code_type'(LetterCodes[letter_off[4:0]]);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/morse_code_flash_encoder_core.sv =====
// ----------------------------------------------------------------------------
// morse_code_flash_encoder_core
// Turns character codes into timed lamp segments of International Morse code.
// ----------------------------------------------------------------------------
// Each accepted character on req_ is expanded into 2n+1 segments on rsp_ for
// its n dots and dashes: lit segment of dot or dash length, dark symbol gap,
// and a closing dark character gap flagged by rsp_tlast. Digits and upper-case
// letters are mapped; every other code gives only the character gap. The
// segment sequencer emits one segment per cycle while the response side takes
// them, and loads each character from the queue in its idle state. The
// front end takes a character per cycle until its staging register and the
// two-entry code queue behind it are both full.
// Durations come from the csr_ registers and are only stated, never timed;
// rewrite them only while no character is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_flash_encoder_core
   import mcfe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [CharWidth-1:0]     req_tdata,   // [7:0] character
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [DurWidth-1:0]           rsp_tdata,   // [15:0] duration
   output logic                          rsp_tuser,   // [0] light_on
   output logic                          rsp_tlast,   // final_segment
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [DurWidth-1:0]      csr_data
);

   timing_type   timing_ff;
   timing_type   timing_in;
   code_msg_type push_msg;
   code_msg_type head;
   logic         queue_full;
   logic         pop;

   assign csr_ready = 1'b1;

   always_comb begin
      timing_in = timing_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrDotDuration:  timing_in.dot_duration  = csr_data;
            CsrDashDuration: timing_in.dash_duration = csr_data;
            CsrSymbolGap:    timing_in.symbol_gap    = csr_data;
            CsrCharacterGap: timing_in.character_gap = csr_data;
            default:         timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.dot_duration  <= DotDurationReset;
         timing_ff.dash_duration <= DashDurationReset;
         timing_ff.symbol_gap    <= SymbolGapReset;
         timing_ff.character_gap <= CharacterGapReset;
      end else begin
         timing_ff <= timing_in;
      end
   end

   mcfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_msg   (push_msg)
   );

   mcfe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_msg (push_msg),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   mcfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .timing     (timing_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mcfe_front.sv =====
// ----------------------------------------------------------------------------
// mcfe_front
// Accepts characters, looks up their Morse code and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfe_front
   import mcfe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [CharWidth-1:0] req_tdata,   // [7:0] character
   input  wire logic                 queue_full,
   output code_msg_type              push_msg
);

   logic     stage_valid_ff;
   logic     stage_valid_in;
   code_type stage_code_ff;
   logic     accept;
   logic     push;

   assign push       = stage_valid_ff && !queue_full;
   assign req_tready = !stage_valid_ff || !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_code_ff <= lookup_code(req_tdata);
      end
   end

   assign push_msg.valid = push;
   assign push_msg.code  = stage_code_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mcfe_fifo.sv =====
// ----------------------------------------------------------------------------
// mcfe_fifo
// Short queue of looked-up codes between the front and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcfe_fifo
   import mcfe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire code_msg_type push_msg,
   output logic        full,
   input  wire logic   pop,
   output code_msg_type head
);

   code_type                    mem [QueueDepth];
   logic [QueuePtrWidth-1:0]    wr_ptr_ff;
   logic [QueuePtrWidth-1:0]    wr_ptr_in;
   logic [QueuePtrWidth-1:0]    rd_ptr_ff;
   logic [QueuePtrWidth-1:0]    rd_ptr_in;
   logic [QueueCountWidth-1:0]  count_ff;
   logic [QueueCountWidth-1:0]  count_in;
   logic                        do_pop;

   assign full       = (count_ff == QueueCountWidth'(QueueDepth));
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.code  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_msg.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_msg.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_msg.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_msg.valid) begin
         mem[wr_ptr_ff] <= push_msg.code;
      end
   end

   `ASSERT_NEVER(a_push_when_full, clock, reset, push_msg.valid && full)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
                   count_ff <= QueueCountWidth'(QueueDepth))
   `ASSERT_IMPLIES(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

// ===== rtl/core/mcfe_back.sv =====
// ----------------------------------------------------------------------------
// mcfe_back
// Segment sequencer: expands one code into lit and dark segments.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcfe_back
   import mcfe_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire code_msg_type        head,
   output logic                     pop,
   input  wire timing_type          timing,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DurWidth-1:0]      rsp_tdata,   // [15:0] duration
   output logic                     rsp_tuser,   // [0] light_on
   output logic                     rsp_tlast    // final_segment
);

   back_state_type          state_ff;
   back_state_type          state_in;
   logic [CountWidth-1:0]   count_ff;
   logic [DashWidth-1:0]    dashes_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_light_ff;
   logic [DurWidth-1:0]     rsp_dur_ff;
   logic                    rsp_last_ff;
   logic                    out_free;
   logic                    emit;
   logic                    seg_light;
   logic [DurWidth-1:0]     seg_dur;
   logic                    seg_last;
   logic                    shift;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               state_in = (head.code.count == '0) ? BK_END : BK_LIT;
            end
         end
         BK_LIT: begin
            if (out_free) begin
               state_in = BK_GAP;
            end
         end
         BK_GAP: begin
            if (out_free) begin
               state_in = (count_ff == CountWidth'(1)) ? BK_END : BK_LIT;
            end
         end
         BK_END: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      shift     = 1'b0;
      seg_light = 1'b0;
      seg_dur   = timing.character_gap;
      seg_last  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop = head.valid;
         end
         BK_LIT: begin
            emit      = out_free;
            seg_light = 1'b1;
            seg_dur   = dashes_ff[0] ? timing.dash_duration : timing.dot_duration;
         end
         BK_GAP: begin
            emit    = out_free;
            shift   = out_free;
            seg_dur = timing.symbol_gap;
         end
         BK_END: begin
            emit     = out_free;
            seg_dur  = timing.character_gap;
            seg_last = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         count_ff  <= head.code.count;
         dashes_ff <= head.code.dashes;
      end else if (shift) begin
         count_ff  <= count_ff - 1'b1;
         dashes_ff <= dashes_ff >> 1;
      end
      if (emit) begin
         rsp_light_ff <= seg_light;
         rsp_dur_ff   <= seg_dur;
         rsp_last_ff  <= seg_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dur_ff;
   assign rsp_tuser  = rsp_light_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPLIES(a_final_dark, clock, reset, rsp_valid_ff && rsp_last_ff, !rsp_light_ff)
   `ASSERT_IMPLIES(a_symbols_left, clock, reset,
                   state_ff == BK_LIT || state_ff == BK_GAP,
                   count_ff != '0 && count_ff <= MaxSymbols)
   `ASSERT_NEXT(a_lit_then_gap, clock, reset, state_ff == BK_LIT && out_free,
                state_ff == BK_GAP)
   `ASSERT_IMPLIES(a_pop_only_idle, clock, reset, pop, state_ff == BK_IDLE && head.valid)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Morse flash encoder core testbench
// Streams characters into the core. A scoreboard expands each accepted
// character into its lit and dark segments from its own Morse table and its own
// copy of the timing registers. Every segment that the core returns is checked
// field by field against the oldest pending segment. Both sides idle at random,
// the result side holds off for a long stretch once, and the timing registers
// are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import mcfe_pkg::*;
;

   localparam int CsrCount     = 4;
   localparam int PhaseCount   = 6;
   localparam int PhaseItems   = 40;
   localparam int MaxMs        = 65535;
   localparam int LongHold     = 100;
   localparam int SettleCycles = 16;

   typedef struct packed {
      logic                light_on;
      logic [DurWidth-1:0] duration;
      logic                final_segment;
   } segment_type;

   class segment_scoreboard;
      logic [DurWidth-1:0] dot_ms;
      logic [DurWidth-1:0] dash_ms;
      logic [DurWidth-1:0] symbol_gap_ms;
      logic [DurWidth-1:0] char_gap_ms;
      segment_type         awaited[$];
      int                  mismatches;

      function new();
         dot_ms        = 16'd250;
         dash_ms       = 16'd500;
         symbol_gap_ms = 16'd500;
         char_gap_ms   = 16'd500;
         mismatches    = 0;
      endfunction

      function void write_register(logic [CsrIndexWidth-1:0] idx, logic [DurWidth-1:0] value);
         case (idx)
            CsrDotDuration:  dot_ms        = value;
            CsrDashDuration: dash_ms       = value;
            CsrSymbolGap:    symbol_gap_ms = value;
            CsrCharacterGap: char_gap_ms   = value;
            default: ;
         endcase
      endfunction

      function string morse_pattern(logic [CharWidth-1:0] ch);
         case (ch)
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            default: return "";
         endcase
      endfunction

      function void note_char(logic [CharWidth-1:0] ch);
         string       marks;
         segment_type seg;
         marks = morse_pattern(ch);
         for (int i = 0; i < marks.len(); i++) begin
            seg.light_on      = 1'b1;
            seg.duration      = (marks[i] == "-") ? dash_ms : dot_ms;
            seg.final_segment = 1'b0;
            awaited.push_back(seg);
            seg.light_on = 1'b0;
            seg.duration = symbol_gap_ms;
            awaited.push_back(seg);
         end
         seg.light_on      = 1'b0;
         seg.duration      = char_gap_ms;
         seg.final_segment = 1'b1;
         awaited.push_back(seg);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_segment(logic light_on, logic [DurWidth-1:0] duration, logic final_segment);
         segment_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected segment lit=%0b dur=%0d last=%0b",
                                      light_on, duration, final_segment));
         end else begin
            want = awaited.pop_front();
            if (light_on !== want.light_on) begin
               report_mismatch($sformatf("light_on %0b, want %0b", light_on, want.light_on));
            end
            if (duration !== want.duration) begin
               report_mismatch($sformatf("duration %0d, want %0d", duration, want.duration));
            end
            if (final_segment !== want.final_segment) begin
               report_mismatch($sformatf("final_segment %0b, want %0b",
                                         final_segment, want.final_segment));
            end
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [CharWidth-1:0]     req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [DurWidth-1:0]      rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [DurWidth-1:0]      csr_data;

   segment_scoreboard sb;
   bit                send_idling;
   bit                take_idling;
   bit                hold_request;

   morse_code_flash_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_segment(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end else if (take_idling && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task send_char(logic [CharWidth-1:0] ch);
      req_tdata  <= ch;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_char(ch);
      if (send_idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   task write_csr(logic [CsrIndexWidth-1:0] idx, logic [DurWidth-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, value);
   endtask

   task program_timing(logic [DurWidth-1:0] dot, logic [DurWidth-1:0] dash,
                       logic [DurWidth-1:0] sym_gap, logic [DurWidth-1:0] chr_gap);
      write_csr(CsrDotDuration, dot);
      write_csr(CsrDashDuration, dash);
      write_csr(CsrIndexWidth'($urandom_range(CsrCount, 2 ** CsrIndexWidth - 1)),
                DurWidth'($urandom));
      write_csr(CsrSymbolGap, sym_gap);
      write_csr(CsrCharacterGap, chr_gap);
      csr_valid <= 1'b0;
   endtask

   function logic [DurWidth-1:0] pick_ms(int lowest);
      case ($urandom_range(0, 3))
         0:       return DurWidth'(lowest);
         1:       return DurWidth'(MaxMs);
         default: return DurWidth'($urandom_range(lowest, MaxMs));
      endcase
   endfunction

   function logic [CharWidth-1:0] pick_char();
      int n;
      if ($urandom_range(0, 9) < 7) begin
         n = $urandom_range(0, 35);
         return (n < 10) ? CharWidth'("0" + n) : CharWidth'("A" + n - 10);
      end
      return CharWidth'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [CharWidth-1:0] opening[22] = '{
         "0", "9", "A", "Z", "E", "T", "5", "Q", "B", "a", "z", " ",
         8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7F, 8'h80, "S"
      };
      sb           = new();
      send_idling  = 1'b1;
      take_idling  = 1'b1;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) begin
         send_char(opening[i]);
      end
      wait_for_results();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0:       program_timing(16'd1, 16'hFFFF, 16'd0, 16'd0);
            1:       program_timing(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
            default: program_timing(pick_ms(1), pick_ms(1), pick_ms(0), pick_ms(0));
         endcase
         send_idling = (phase < PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         take_idling = (phase < PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PhaseItems; n++) begin
            if (phase == 2 && n == 5) begin
               hold_request = 1'b1;
            end
            if (phase == 3 && n == 20) begin
               wait_for_results();
            end
            send_char(pick_char());
         end
         wait_for_results();
      end

      repeat (SettleCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== morse_code_flash_encoder_core.f =====
+incdir+rtl/core
rtl/core/mcfe_pkg.sv
rtl/core/mcfe_front.sv
rtl/core/mcfe_fifo.sv
rtl/core/mcfe_back.sv
rtl/core/morse_code_flash_encoder_core.sv
dv/tb.sv
